>>> sv/ubx_nav_frame_parser_defines.svh
// Assertion macros for the UBX navigation frame parser.
`ifndef UBX_NAV_FRAME_PARSER_DEFINES_SVH
`define UBX_NAV_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
`define UBXNAV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ubxnav assertion failed");
`define UBXNAV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubxnav assertion failed");
`else
`define UBXNAV_ASSERT(lbl, prop)
`define UBXNAV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/ubxnav_pkg.sv
// Shared types and constants of the UBX navigation frame parser.
package ubxnav_pkg;

    localparam logic [7:0] SYNC1_BYTE = 8'hB5;
    localparam logic [7:0] SYNC2_BYTE = 8'h62;

    localparam int MAX_FRAME_DEFAULT = 1024;
    localparam int FRAME_OVERHEAD    = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int MIN_PAY_W   = 10;

    localparam logic [7:0]           ACCEPT_CLASS_RST = 8'hFF;
    localparam logic [7:0]           ACCEPT_ID_RST    = 8'h01;
    localparam logic [MIN_PAY_W-1:0] MIN_PAYLOAD_RST  = 10'd80;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCEPT_CLASS = 2'd0,
        REG_ACCEPT_ID    = 2'd1,
        REG_MIN_PAYLOAD  = 2'd2
    } reg_index_t;

    // payload offsets of the captured fields
    localparam logic [15:0] OFS_TOW   = 16'd0;
    localparam logic [15:0] OFS_FIX   = 16'd20;
    localparam logic [15:0] OFS_SATS  = 16'd23;
    localparam logic [15:0] OFS_LON   = 16'd24;
    localparam logic [15:0] OFS_LAT   = 16'd28;
    localparam logic [15:0] OFS_SPEED = 16'd48;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [7:0]           accept_class;
        logic [7:0]           accept_id;
        logic [MIN_PAY_W-1:0] min_payload;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        time_of_week_ms;
        logic signed [31:0] longitude_raw;
        logic signed [31:0] latitude_raw;
        logic [7:0]         fix_type;
        logic [7:0]         satellites;
        logic [31:0]        speed_mm_s;
        logic [31:0]        packet_count;
    } nav_t;

endpackage

>>> sv/ubxnav_byte_if.sv
// Input byte channel.
interface ubxnav_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

>>> sv/ubxnav_cfg_if.sv
// Configuration write channel.
interface ubxnav_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ubxnav_pkg::CFG_INDEX_W-1:0] index;
    logic [ubxnav_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/ubxnav_nav_if.sv
// Decoded navigation result channel.
interface ubxnav_nav_if;
    logic               valid;
    logic               ready;
    logic [31:0]        time_of_week_ms;
    logic signed [31:0] longitude_raw;
    logic signed [31:0] latitude_raw;
    logic [7:0]         fix_type;
    logic [7:0]         satellites;
    logic [31:0]        speed_mm_s;
    logic [31:0]        packet_count;

    modport source (output valid, output time_of_week_ms, output longitude_raw,
                    output latitude_raw, output fix_type, output satellites,
                    output speed_mm_s, output packet_count, input ready);
    modport sink (input valid, input time_of_week_ms, input longitude_raw,
                  input latitude_raw, input fix_type, input satellites,
                  input speed_mm_s, input packet_count, output ready);
endinterface

>>> sv/ubx_nav_frame_parser.sv
// Top level of the UBX navigation frame parser.
//
//  channel | dir | word                              | note
//  rx      | in  | data_byte                         | one serial byte
//  cfg     | in  | index, data                       | always ready
//  nav     | out | tow, lon, lat, fix, sats, speed,  | one per accepted frame
//          |     | packet_count                      |
//
// One byte per cycle sustained: a byte is held in the input register,
// the frame FSM and checksum add update on it, a decoded frame lands in the
// result register. A full result register stalls only the byte that closes
// a good frame.
// Reset: hunting sync, registers at defaults, packet count zero.
`include "ubx_nav_frame_parser_defines.svh"

module ubx_nav_frame_parser #(
    parameter int MAX_FRAME = ubxnav_pkg::MAX_FRAME_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ubxnav_byte_if.sink  rx,
    ubxnav_cfg_if.sink   cfg,
    ubxnav_nav_if.source nav
);
    import ubxnav_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       res_valid_reg, res_valid_next;
    nav_t       res_reg;
    cfg_t       cfg_reg;
    nav_t       result;
    logic       emit;
    logic       proc_en;
    logic       rx_accept;

    assign proc_en   = in_valid_reg && (!res_valid_reg || nav.ready || !emit);
    assign rx.ready  = !in_valid_reg || proc_en;
    assign rx_accept = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    ubxnav_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_en),
        .data_byte (byte_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_accept)
            in_valid_next = 1'b1;
        else if (proc_en)
            in_valid_next = 1'b0;
        res_valid_next = res_valid_reg;
        if (proc_en && emit)
            res_valid_next = 1'b1;
        else if (nav.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cfg_reg.accept_class <= ACCEPT_CLASS_RST;
            cfg_reg.accept_id    <= ACCEPT_ID_RST;
            cfg_reg.min_payload  <= MIN_PAYLOAD_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_ACCEPT_CLASS: cfg_reg.accept_class <= cfg.data[7:0];
                    REG_ACCEPT_ID:    cfg_reg.accept_id    <= cfg.data[7:0];
                    REG_MIN_PAYLOAD:  cfg_reg.min_payload  <= cfg.data[MIN_PAY_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
            byte_reg <= rx.data_byte;
        if (proc_en && emit)
            res_reg <= result;
    end

    assign nav.valid           = res_valid_reg;
    assign nav.time_of_week_ms = res_reg.time_of_week_ms;
    assign nav.longitude_raw   = res_reg.longitude_raw;
    assign nav.latitude_raw    = res_reg.latitude_raw;
    assign nav.fix_type        = res_reg.fix_type;
    assign nav.satellites      = res_reg.satellites;
    assign nav.speed_mm_s      = res_reg.speed_mm_s;
    assign nav.packet_count    = res_reg.packet_count;

    `UBXNAV_ASSERT_NEXT(a_emit_loads_result, proc_en && emit, res_valid_reg)
    `UBXNAV_ASSERT(a_no_result_overwrite, !(res_valid_reg && !nav.ready && proc_en && emit))
    `UBXNAV_ASSERT(a_no_byte_overwrite, !(in_valid_reg && !proc_en && rx.ready))

endmodule

>>> sv/ubxnav_parser.sv
// Frame state machine, Fletcher sums and field capture, one byte per step.
module ubxnav_parser #(
    parameter int MAX_FRAME = ubxnav_pkg::MAX_FRAME_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  ubxnav_pkg::cfg_t  cfg,
    output logic              emit,
    output ubxnav_pkg::nav_t  result
);
    import ubxnav_pkg::*;

    localparam logic [16:0] MaxFrameW = 17'(MAX_FRAME);
    localparam logic [16:0] OverheadW = 17'(FRAME_OVERHEAD);

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  ck_a_reg, ck_a_next;
    logic [31:0] tow_reg, tow_next;
    logic [31:0] lon_reg, lon_next;
    logic [31:0] lat_reg, lat_next;
    logic [31:0] speed_reg, speed_next;
    logic [7:0]  fix_reg, fix_next;
    logic [7:0]  sats_reg, sats_next;
    logic [31:0] count_reg, count_next;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;
    logic [15:0] idx_inc;
    logic [4:0]  lane;
    logic        frame_ok;

    assign sum_a_add = sum_a_reg + data_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_full  = {data_byte, len_reg[7:0]};
    assign idx_inc   = idx_reg + 16'd1;
    assign lane      = {idx_reg[1:0], 3'b000};

    assign frame_ok = (ck_a_reg == sum_a_reg) && (data_byte == sum_b_reg) &&
                      (class_reg == cfg.accept_class) && (id_reg == cfg.accept_id) &&
                      (len_reg >= {6'd0, cfg.min_payload});
    assign emit     = (phase_reg == PH_CK_B) && frame_ok;

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next  = ck_a_reg;
        tow_next   = tow_reg;
        lon_next   = lon_reg;
        lat_next   = lat_reg;
        speed_next = speed_reg;
        fix_next   = fix_reg;
        sats_next  = sats_reg;
        count_next = count_reg;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (data_byte == SYNC1_BYTE)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (data_byte == SYNC2_BYTE)
                begin
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_CLASS;
                end
                else if (data_byte != SYNC1_BYTE)
                    phase_next = PH_SYNC1;
            end
            PH_CLASS:
            begin
                class_next = data_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = data_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, data_byte};
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next   = len_full;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                idx_next   = 16'd0;
                tow_next   = 32'd0;
                lon_next   = 32'd0;
                lat_next   = 32'd0;
                speed_next = 32'd0;
                fix_next   = 8'd0;
                sats_next  = 8'd0;
                if (({1'b0, len_full} + OverheadW) > MaxFrameW)
                    phase_next = PH_SYNC1;
                else if (len_full == 16'd0)
                    phase_next = PH_CK_A;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (idx_reg[15:2] == OFS_TOW[15:2])
                    tow_next[lane +: 8] = data_byte;
                if (idx_reg == OFS_FIX)
                    fix_next = data_byte;
                if (idx_reg == OFS_SATS)
                    sats_next = data_byte;
                if (idx_reg[15:2] == OFS_LON[15:2])
                    lon_next[lane +: 8] = data_byte;
                if (idx_reg[15:2] == OFS_LAT[15:2])
                    lat_next[lane +: 8] = data_byte;
                if (idx_reg[15:2] == OFS_SPEED[15:2])
                    speed_next[lane +: 8] = data_byte;
                idx_next = idx_inc;
                if (idx_inc >= len_reg)
                    phase_next = PH_CK_A;
            end
            PH_CK_A:
            begin
                ck_a_next  = data_byte;
                phase_next = PH_CK_B;
            end
            PH_CK_B:
            begin
                phase_next = PH_SYNC1;
                if (frame_ok)
                    count_next = count_reg + 32'd1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            count_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            ck_a_reg  <= ck_a_next;
            tow_reg   <= tow_next;
            lon_reg   <= lon_next;
            lat_reg   <= lat_next;
            speed_reg <= speed_next;
            fix_reg   <= fix_next;
            sats_reg  <= sats_next;
        end
    end

    always_comb
    begin
        result.time_of_week_ms = tow_reg;
        result.longitude_raw   = lon_reg;
        result.latitude_raw    = lat_reg;
        result.fix_type        = fix_reg;
        result.satellites      = sats_reg;
        result.speed_mm_s      = speed_reg;
        result.packet_count    = count_reg + 32'd1;
    end

endmodule
